[rtl/core/mclp_pkg.sv]
// shared types, character codes and keyword table of the mail command line parser
`timescale 1ns / 1ps
`default_nettype none
package mclp_pkg;

    localparam int MAX_COMMAND_CHARS = 4;
    localparam int MAX_ARG_CHARS     = 40;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int CHAR_W = 7;
    localparam int CODE_W = 4;
    localparam int PH_W   = 2;
    localparam int KW_W   = 32;
    localparam int KW_LEN_W = 4;
    localparam int KW_COUNT = 10;

    // parser phases
    localparam logic [PH_W-1:0] PH_CMD     = 2'd0;
    localparam logic [PH_W-1:0] PH_ARG1    = 2'd1;
    localparam logic [PH_W-1:0] PH_ARG2    = 2'd2;
    localparam logic [PH_W-1:0] PH_DISCARD = 2'd3;

    // command codes
    localparam logic [CODE_W-1:0] CMD_NONE = 4'd10;

    // character codes
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE     = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_CASE_DIFF = 8'h20;

    // keywords packed with the first character in the low byte
    localparam logic [KW_W-1:0] KW_WORD [KW_COUNT] = '{
        32'h00504F54,   // TOP
        32'h52455355,   // USER
        32'h53534150,   // PASS
        32'h54415453,   // STAT
        32'h5453494C,   // LIST
        32'h52544552,   // RETR
        32'h454C4544,   // DELE
        32'h504F4F4E,   // NOOP
        32'h54455352,   // RSET
        32'h54495551    // QUIT
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
    };

    typedef struct packed {
        logic              kind;
        logic              arg_number;
        logic [POS_W-1:0]  arg_position;
        logic [CHAR_W-1:0] arg_char;
        logic [CODE_W-1:0] command_code;
        logic              line_valid;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/mclp_match.sv]
// case-folded command word compare against the keyword table
`timescale 1ns / 1ps
`default_nettype none
module mclp_match #(
    parameter int MAX_COMMAND_CHARS = mclp_pkg::MAX_COMMAND_CHARS,
    parameter int CL_W              = $clog2(MAX_COMMAND_CHARS + 1)
) (
    input  wire logic [8*MAX_COMMAND_CHARS-1:0]   i_word,
    input  wire logic [CL_W-1:0]                  i_len,
    output logic      [mclp_pkg::CODE_W-1:0]      o_code
);

    localparam int WORD_W = 8 * MAX_COMMAND_CHARS;

    logic [mclp_pkg::KW_LEN_W-1:0] w_len;

    assign w_len = mclp_pkg::KW_LEN_W'(i_len);

    // scan downward so the lowest matching entry wins
    always_comb begin
        o_code = mclp_pkg::CMD_NONE;
        for (int k = mclp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (w_len == mclp_pkg::KW_LEN[k] &&
                i_word == WORD_W'(mclp_pkg::KW_WORD[k])) begin
                o_code = mclp_pkg::CODE_W'(k);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/mclp_step.sv]
// per-byte next state and result decision of the line parser
`timescale 1ns / 1ps
`default_nettype none
module mclp_step #(
    parameter int MAX_COMMAND_CHARS = mclp_pkg::MAX_COMMAND_CHARS,
    parameter int MAX_ARG_CHARS     = mclp_pkg::MAX_ARG_CHARS,
    parameter int CL_W              = $clog2(MAX_COMMAND_CHARS + 1),
    parameter int AL_W              = $clog2(MAX_ARG_CHARS + 1)
) (
    input  wire logic [mclp_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic [mclp_pkg::PH_W-1:0]      i_phase,
    input  wire logic                           i_cr,
    input  wire logic [8*MAX_COMMAND_CHARS-1:0] i_word,
    input  wire logic [CL_W-1:0]                i_clen,
    input  wire logic [AL_W-1:0]                i_alen,
    output logic      [mclp_pkg::PH_W-1:0]      o_phase,
    output logic                                o_cr,
    output logic      [8*MAX_COMMAND_CHARS-1:0] o_word,
    output logic      [CL_W-1:0]                o_clen,
    output logic      [AL_W-1:0]                o_alen,
    output logic                                o_emit,
    output mclp_pkg::t_result                   o_result
);

    localparam int WORD_W = 8 * MAX_COMMAND_CHARS;

    logic [mclp_pkg::CODE_W-1:0] w_code;
    logic [mclp_pkg::BYTE_W-1:0] w_upper;
    logic                        w_bad;

    mclp_match #(
        .MAX_COMMAND_CHARS (MAX_COMMAND_CHARS),
        .CL_W              (CL_W)
    ) u_match (
        .i_word (i_word),
        .i_len  (i_clen),
        .o_code (w_code)
    );

    assign w_bad   = (i_byte < mclp_pkg::CH_SPACE) || (i_byte > mclp_pkg::CH_TILDE);
    assign w_upper = (i_byte >= mclp_pkg::CH_LOWER_A && i_byte <= mclp_pkg::CH_LOWER_Z)
                   ? i_byte - mclp_pkg::CH_CASE_DIFF : i_byte;

    always_comb begin
        logic w_end;
        logic w_end_ok;

        w_end    = 1'b0;
        w_end_ok = 1'b0;
        o_phase  = i_phase;
        o_cr     = i_cr;
        o_word   = i_word;
        o_clen   = i_clen;
        o_alen   = i_alen;
        o_emit   = 1'b0;
        o_result = '0;
        o_result.command_code = mclp_pkg::CMD_NONE;

        if (i_phase == mclp_pkg::PH_DISCARD) begin
            if (i_byte == mclp_pkg::CH_CR) begin
                o_cr = 1'b1;
            end else if (i_byte == mclp_pkg::CH_LF && i_cr) begin
                w_end = 1'b1;
            end else begin
                o_cr = 1'b0;
            end
        end else if (i_cr) begin
            if (i_byte == mclp_pkg::CH_LF) begin
                w_end    = 1'b1;
                w_end_ok = 1'b1;
            end else begin
                o_phase = mclp_pkg::PH_DISCARD;
                o_cr    = (i_byte == mclp_pkg::CH_CR);
            end
        end else if (i_byte == mclp_pkg::CH_SPACE) begin
            unique case (i_phase)
                mclp_pkg::PH_CMD:  o_phase = mclp_pkg::PH_ARG1;
                mclp_pkg::PH_ARG1: o_phase = mclp_pkg::PH_ARG2;
                default:           o_phase = mclp_pkg::PH_DISCARD;
            endcase
            o_alen = '0;
        end else if (i_byte == mclp_pkg::CH_CR) begin
            o_cr = 1'b1;
        end else if (i_phase == mclp_pkg::PH_CMD) begin
            if (i_clen >= CL_W'(MAX_COMMAND_CHARS) || w_bad) begin
                o_phase = mclp_pkg::PH_DISCARD;
            end else begin
                for (int i = 0; i < MAX_COMMAND_CHARS; i++) begin
                    if (i_clen == CL_W'(i)) begin
                        o_word[8*i +: 8] = w_upper;
                    end
                end
                o_clen = CL_W'(i_clen + 1'b1);
            end
        end else begin
            if (i_alen >= AL_W'(MAX_ARG_CHARS) || w_bad) begin
                o_phase = mclp_pkg::PH_DISCARD;
            end else begin
                o_emit                = 1'b1;
                o_result.arg_number   = (i_phase == mclp_pkg::PH_ARG2);
                o_result.arg_position = mclp_pkg::POS_W'(i_alen);
                o_result.arg_char     = i_byte[mclp_pkg::CHAR_W-1:0];
                o_alen                = AL_W'(i_alen + 1'b1);
            end
        end

        // line end record, then back to a fresh line
        if (w_end) begin
            o_emit                = 1'b1;
            o_result.kind         = 1'b1;
            o_result.command_code = w_end_ok ? w_code : mclp_pkg::CMD_NONE;
            o_result.line_valid   = w_end_ok && (w_code != mclp_pkg::CMD_NONE);
            o_phase               = mclp_pkg::PH_CMD;
            o_cr                  = 1'b0;
            o_word                = {WORD_W{1'b0}};
            o_clen                = '0;
            o_alen                = '0;
        end
    end

endmodule
`default_nettype wire

[rtl/core/mail_command_line_parser.sv]
// top level of the mail command line parser
// The parser takes one byte per cycle unless a waiting result stalls it, and
// gives at most one result per byte: an argument character as soon as it arrives,
// or a line end record after CR LF that carries the keyword code of the command
// word and whether the line is valid. A byte is held in an input register,
// decided in one pass through the per-byte logic and the parallel keyword compare,
// and its result lands in an output register; throughput is one byte every cycle,
// set by the single update of the line state per byte, and a result left waiting
// in the output register holds the next byte in the input register.
// Argument characters of a line whose record shows line_valid low are to be
// dropped by the consumer.
`timescale 1ns / 1ps
`default_nettype none
module mail_command_line_parser #(
    parameter int MAX_COMMAND_CHARS = mclp_pkg::MAX_COMMAND_CHARS,
    parameter int MAX_ARG_CHARS     = mclp_pkg::MAX_ARG_CHARS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [mclp_pkg::BYTE_W-1:0]    i_byte_in,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_kind,
    output logic                                o_arg_number,
    output logic      [mclp_pkg::POS_W-1:0]     o_arg_position,
    output logic      [mclp_pkg::CHAR_W-1:0]    o_arg_char,
    output logic      [mclp_pkg::CODE_W-1:0]    o_command_code,
    output logic                                o_line_valid
);

    localparam int CL_W   = $clog2(MAX_COMMAND_CHARS + 1);
    localparam int AL_W   = $clog2(MAX_ARG_CHARS + 1);
    localparam int WORD_W = 8 * MAX_COMMAND_CHARS;

    logic                         r_in_valid;
    logic [mclp_pkg::BYTE_W-1:0]  r_byte;
    logic [mclp_pkg::PH_W-1:0]    r_phase;
    logic                         r_cr;
    logic [WORD_W-1:0]            r_word;
    logic [CL_W-1:0]              r_clen;
    logic [AL_W-1:0]              r_alen;
    logic                         r_out_valid;
    mclp_pkg::t_result            r_out;

    logic [mclp_pkg::PH_W-1:0]    n_phase;
    logic                         n_cr;
    logic [WORD_W-1:0]            n_word;
    logic [CL_W-1:0]              n_clen;
    logic [AL_W-1:0]              n_alen;
    logic                         w_emit;
    mclp_pkg::t_result            w_result;
    logic                         w_advance;

    mclp_step #(
        .MAX_COMMAND_CHARS (MAX_COMMAND_CHARS),
        .MAX_ARG_CHARS     (MAX_ARG_CHARS),
        .CL_W              (CL_W),
        .AL_W              (AL_W)
    ) u_step (
        .i_byte   (r_byte),
        .i_phase  (r_phase),
        .i_cr     (r_cr),
        .i_word   (r_word),
        .i_clen   (r_clen),
        .i_alen   (r_alen),
        .o_phase  (n_phase),
        .o_cr     (n_cr),
        .o_word   (n_word),
        .o_clen   (n_clen),
        .o_alen   (n_alen),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // the held byte moves on once the output register is free or being emptied
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mclp_pkg::PH_CMD;
            r_cr    <= 1'b0;
            r_word  <= {WORD_W{1'b0}};
            r_clen  <= '0;
            r_alen  <= '0;
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_word  <= n_word;
            r_clen  <= n_clen;
            r_alen  <= n_alen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_arg_number   = r_out.arg_number;
    assign o_arg_position = r_out.arg_position;
    assign o_arg_char     = r_out.arg_char;
    assign o_command_code = r_out.command_code;
    assign o_line_valid   = r_out.line_valid;

    // character results never carry a command
    a_char_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.kind) |->
            (r_out.command_code == mclp_pkg::CMD_NONE && !r_out.line_valid))
        else $error("argument character carries a command code");

    // a valid line always names a keyword
    a_valid_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_valid) |-> (r_out.command_code != mclp_pkg::CMD_NONE))
        else $error("valid line without keyword");

    // a line end record restarts the parser
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit && w_result.kind) |=>
            (r_phase == mclp_pkg::PH_CMD && !r_cr && r_clen == '0 && r_alen == '0))
        else $error("line state not cleared after line end");

    // every produced result is presented
    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> r_out_valid)
        else $error("result lost");

    // stored command length stays within the word
    a_clen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clen <= CL_W'(MAX_COMMAND_CHARS))
        else $error("command length overflow");

endmodule
`default_nettype wire
